FILE: sv/cnd_pkg.sv
// ----------------------------------------------------------------------------
// cnd_pkg
// Shared constants, types and helpers of the conditional-neighbour despeckle
// filter.
// ----------------------------------------------------------------------------
package cnd_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int PIX_W      = 8;
    localparam int LINE_W     = 2 * PIX_W;       // {raw, filtered} per column

    localparam int THR_W      = 8;
    localparam int ROWS_W     = 11;
    localparam int COLS_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int SUM_W      = PIX_W + 2;       // up to four pixels
    localparam int DIV3_MUL   = 683;             // ceil(2^11 / 3)
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = SUM_W + 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_ROWS      = 2'd1,
        CFG_COLS      = 2'd2
    } cfg_idx_t;

    // Item held between the line read and the write-back.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             last_col;
        logic             has_up;
        logic             has_down;
        logic             emit;
        logic             frame_end;
        logic             write_raw;
        logic [PIX_W-1:0] pix;
        logic             fwd_hit;
        logic [PIX_W-1:0] fwd_raw;
    } stage_t;

    function automatic logic is_far(input logic [PIX_W-1:0] a,
                                    input logic [PIX_W-1:0] b,
                                    input logic [THR_W-1:0] thr);
        logic [PIX_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > thr;
    endfunction

endpackage

FILE: sv/conditional_neighbor_despeckle.sv
// ----------------------------------------------------------------------------
// conditional_neighbor_despeckle
// Four-neighbour conditional-mean despeckle filter over a raster pixel stream.
//
// Raw pixels enter on the in channel (in_valid/in_ready, req_type, pixel_in);
// filtered pixels leave on the out channel (out_valid/out_ready, pixel_out,
// frame_end), one row behind the input. First-row items give no output. After
// the last pixel of a frame, each further item (its data ignored) gives one
// pixel of the last row; frame_end marks the last one. Drain items at other
// times are taken and give nothing.
// Registers are written on the cfg channel (always ready); writing the row or
// column count restarts the frame. Write only while the block is idle.
// An item and its line read are registered in the issue stage, its result in
// the output register. One item per cycle while the output is not stalled, set
// by the single read-modify-write pass over the line memory ({raw, filtered} per
// column; the right neighbour is forwarded from the write-back on a collision).
// Reset clears counters, drain flag and pipeline valids and loads the register
// defaults; the line memory is not cleared. When the receiver stalls, the
// output register holds, the item behind it holds, and in_ready drops.
// ----------------------------------------------------------------------------
module conditional_neighbor_despeckle
    import cnd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [PIX_W-1:0]      pixel_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  frame_end
);

    logic [THR_W-1:0]  threshold_reg;
    logic [ROWS_W-1:0] rows_in_use_reg;
    logic [COLS_W-1:0] cols_in_use_reg;
    logic [COL_W-1:0]  col_count_reg, col_count_next;
    logic [ROW_W-1:0]  row_count_reg, row_count_next;
    logic              draining_reg, draining_next;
    logic [PIX_W-1:0]  left_filtered_reg;
    logic              s1_valid_reg;
    stage_t            s1_reg, s1_next;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  pixel_out_reg;
    logic              frame_end_reg;

    logic [COLS_W-1:0] eff_cols, col_plus;
    logic [ROWS_W-1:0] eff_rows, row_plus;
    logic              last_col, last_row;
    logic              accept, active, advance;

    logic [LINE_W-1:0] rd_a, rd_b;
    logic [PIX_W-1:0]  centre, up, right, wr_raw, mean, filt;
    logic [SUM_W-1:0]  sum;
    logic [2:0]        cnt;
    logic              noisy, has_left, has_right;
    logic [PROD_W-1:0] prod;

    // ---------------- geometry ----------------
    always_comb
    begin
        priority if (cols_in_use_reg < COLS_W'(2))
            eff_cols = COLS_W'(2);
        else if (cols_in_use_reg > COLS_W'(MAX_COLS))
            eff_cols = COLS_W'(MAX_COLS);
        else
            eff_cols = cols_in_use_reg;

        priority if (rows_in_use_reg < ROWS_W'(2))
            eff_rows = ROWS_W'(2);
        else if (rows_in_use_reg > ROWS_W'(MAX_ROWS))
            eff_rows = ROWS_W'(MAX_ROWS);
        else
            eff_rows = rows_in_use_reg;
    end

    assign col_plus = COLS_W'(col_count_reg) + COLS_W'(1);
    assign row_plus = ROWS_W'(row_count_reg) + ROWS_W'(1);
    assign last_col = (col_plus == eff_cols);
    assign last_row = (row_plus == eff_rows);

    // ---------------- handshake ----------------
    assign advance   = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign active    = draining_reg || !req_type;
    assign cfg_ready = 1'b1;

    // ---------------- line memory ----------------
    cnd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk     (clk),
        .we      (advance),
        .waddr   (s1_reg.col),
        .wdata   ({wr_raw, filt}),
        .re      (accept),
        .raddr_a (col_count_reg),
        .raddr_b (col_plus[COL_W-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // ---------------- issue stage ----------------
    always_comb
    begin
        s1_next.col       = col_count_reg;
        s1_next.last_col  = last_col;
        s1_next.has_up    = draining_reg || (row_count_reg > ROW_W'(1));
        s1_next.has_down  = !draining_reg;
        s1_next.emit      = draining_reg || (row_count_reg != '0);
        s1_next.frame_end = draining_reg && last_col;
        s1_next.write_raw = !draining_reg;
        s1_next.pix       = pixel_in;
        // the entry being written back this cycle is the one read as right
        s1_next.fwd_hit   = s1_valid_reg && (s1_reg.col == col_plus[COL_W-1:0]);
        s1_next.fwd_raw   = wr_raw;

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        draining_next  = draining_reg;
        if (accept && active)
        begin
            col_count_next = last_col ? '0 : col_plus[COL_W-1:0];
            if (draining_reg)
            begin
                if (last_col)
                begin
                    draining_next  = 1'b0;
                    row_count_next = '0;
                end
            end
            else if (last_col)
            begin
                if (last_row)
                begin
                    row_count_next = '0;
                    draining_next  = 1'b1;
                end
                else
                begin
                    row_count_next = row_plus[ROW_W-1:0];
                end
            end
        end
    end

    // ---------------- filter stage ----------------
    assign centre    = rd_a[LINE_W-1:PIX_W];
    assign up        = rd_a[PIX_W-1:0];
    assign right     = s1_reg.fwd_hit ? s1_reg.fwd_raw : rd_b[LINE_W-1:PIX_W];
    assign has_left  = (s1_reg.col != '0);
    assign has_right = !s1_reg.last_col;
    assign wr_raw    = s1_reg.write_raw ? s1_reg.pix : centre;

    always_comb
    begin
        sum   = '0;
        cnt   = '0;
        noisy = 1'b0;
        if (s1_reg.has_up)
        begin
            noisy = noisy || is_far(centre, up, threshold_reg);
            sum   = sum + SUM_W'(up);
            cnt   = cnt + 3'd1;
        end
        if (s1_reg.has_down)
        begin
            noisy = noisy || is_far(centre, s1_reg.pix, threshold_reg);
            sum   = sum + SUM_W'(s1_reg.pix);
            cnt   = cnt + 3'd1;
        end
        if (has_left)
        begin
            noisy = noisy || is_far(centre, left_filtered_reg, threshold_reg);
            sum   = sum + SUM_W'(left_filtered_reg);
            cnt   = cnt + 3'd1;
        end
        if (has_right)
        begin
            noisy = noisy || is_far(centre, right, threshold_reg);
            sum   = sum + SUM_W'(right);
            cnt   = cnt + 3'd1;
        end
    end

    // divide by three: reciprocal multiply, exact for sums up to three pixels
    assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);

    always_comb
    begin
        unique case (cnt)
            3'd2:    mean = sum[PIX_W:1];
            3'd3:    mean = prod[DIV3_SHIFT +: PIX_W];
            3'd4:    mean = sum[PIX_W+1:2];
            default: mean = centre;
        endcase
    end

    assign filt = noisy ? mean : centre;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= THR_W'(1);
            rows_in_use_reg   <= ROWS_W'(20);
            cols_in_use_reg   <= COLS_W'(30);
            col_count_reg     <= '0;
            row_count_reg     <= '0;
            draining_reg      <= 1'b0;
            left_filtered_reg <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_THRESHOLD:
                    begin
                        threshold_reg <= cfg_data[THR_W-1:0];
                    end
                    CFG_ROWS:
                    begin
                        rows_in_use_reg   <= cfg_data[ROWS_W-1:0];
                        col_count_reg     <= '0;
                        row_count_reg     <= '0;
                        draining_reg      <= 1'b0;
                        left_filtered_reg <= '0;
                    end
                    CFG_COLS:
                    begin
                        cols_in_use_reg   <= cfg_data[COLS_W-1:0];
                        col_count_reg     <= '0;
                        row_count_reg     <= '0;
                        draining_reg      <= 1'b0;
                        left_filtered_reg <= '0;
                    end
                    default:
                    begin
                        threshold_reg <= threshold_reg;
                    end
                endcase
            end
            else
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                draining_reg  <= draining_next;
                if (advance && s1_reg.emit)
                begin
                    left_filtered_reg <= filt;
                end
            end

            if (accept && active)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance && s1_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && active)
        begin
            s1_reg <= s1_next;
        end
        if (advance && s1_reg.emit)
        begin
            pixel_out_reg <= filt;
            frame_end_reg <= s1_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

endmodule

FILE: sv/cnd_ram.sv
// ----------------------------------------------------------------------------
// cnd_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module cnd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: sv/cnd_checker.sv
// ----------------------------------------------------------------------------
// cnd_checker
// Port-level checks of the despeckle filter, bound to the top level.
// ----------------------------------------------------------------------------
module cnd_checker
    import cnd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [PIX_W-1:0]      pixel_out,
    input logic                  frame_end
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_end))
        else $error("stalled output changed");

    // input back-pressure only comes from a blocked output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // configuration writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg channel stalled");

endmodule

bind conditional_neighbor_despeckle cnd_checker u_cnd_checker (.*);

FILE: dv/conditional_neighbor_despeckle_tb.sv
// ----------------------------------------------------------------------------
// conditional_neighbor_despeckle_tb
// Self-checking bench for the four-neighbour despeckle filter. A short set of
// hand-built frames comes first, then random frames under changing threshold
// and geometry. A cycle-free model of the filter predicts every output
// transfer. Both handshake sides insert random gaps.
// ----------------------------------------------------------------------------
module conditional_neighbor_despeckle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cnd_pkg::*;

    localparam logic                 REQ_PIXEL     = 1'b0;
    localparam logic                 REQ_DRAIN     = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                   TARGET_ITEMS  = 1950;
    localparam int                   PHASE_CAP     = 250;
    localparam int                   SETTLE_CYCLES = 6;
    localparam int                   STALL_LIMIT   = 2000;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } filtered_px_t;

    class despeckle_scoreboard;
        logic [PIX_W-1:0]  raw_row  [MAX_COLS];
        logic [PIX_W-1:0]  filt_row [MAX_COLS];
        logic [PIX_W-1:0]  left_px;
        int unsigned       row_pos;
        int unsigned       col_pos;
        bit                draining;
        logic [THR_W-1:0]  thr;
        logic [ROWS_W-1:0] rows_reg;
        logic [COLS_W-1:0] cols_reg;
        filtered_px_t      due_q [$];
        int                errors;
        int                pixels_checked;
        int                frames_checked;

        function new();
            thr            = 8'd1;
            rows_reg       = 11'd20;
            cols_reg       = 7'd30;
            errors         = 0;
            pixels_checked = 0;
            frames_checked = 0;
            restart();
        endfunction

        function void restart();
            left_px  = '0;
            row_pos  = 0;
            col_pos  = 0;
            draining = 1'b0;
        endfunction

        function int unsigned frame_rows();
            if (rows_reg < 2) return 2;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        function int unsigned frame_cols();
            if (cols_reg < 2) return 2;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: thr = data[THR_W-1:0];
                CFG_ROWS:
                begin
                    rows_reg = data[ROWS_W-1:0];
                    restart();
                end
                CFG_COLS:
                begin
                    cols_reg = data[COLS_W-1:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        function bit differs(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
            logic [PIX_W-1:0] d;
            d = (a > b) ? (a - b) : (b - a);
            return d > thr;
        endfunction

        // Up and left come from the filtered side, right and down are raw.
        function logic [PIX_W-1:0] despeckle_px(int unsigned col, int unsigned cols,
                                                bit has_up, bit has_down,
                                                logic [PIX_W-1:0] down);
            logic [PIX_W-1:0] centre;
            int unsigned      total;
            int unsigned      n;
            bit               noisy;
            centre = raw_row[col];
            total  = 0;
            n      = 0;
            noisy  = 1'b0;
            if (has_up)
            begin
                noisy |= differs(centre, filt_row[col]);
                total += filt_row[col];
                n++;
            end
            if (has_down)
            begin
                noisy |= differs(centre, down);
                total += down;
                n++;
            end
            if (col > 0)
            begin
                noisy |= differs(centre, left_px);
                total += left_px;
                n++;
            end
            if (col + 1 < cols)
            begin
                noisy |= differs(centre, raw_row[col + 1]);
                total += raw_row[col + 1];
                n++;
            end
            if (noisy && n != 0) return PIX_W'(total / n);
            return centre;
        endfunction

        // Returns 0 when the item is dropped by the block.
        function bit take_item(logic req, logic [PIX_W-1:0] pix);
            int unsigned      cols;
            int unsigned      rows;
            int unsigned      col;
            logic [PIX_W-1:0] v;
            filtered_px_t     r;
            cols = frame_cols();
            rows = frame_rows();
            if (col_pos >= cols) col_pos = 0;
            col = col_pos;
            if (draining)
            begin
                v             = despeckle_px(col, cols, 1'b1, 1'b0, '0);
                filt_row[col] = v;
                left_px       = v;
                col_pos       = col + 1;
                r.pixel       = v;
                r.frame_end   = (col_pos >= cols);
                due_q.push_back(r);
                if (r.frame_end) restart();
                return 1'b1;
            end
            if (req == REQ_DRAIN) return 1'b0;
            if (row_pos > 0)
            begin
                v             = despeckle_px(col, cols, row_pos > 1, 1'b1, pix);
                filt_row[col] = v;
                left_px       = v;
                r.pixel       = v;
                r.frame_end   = 1'b0;
                due_q.push_back(r);
            end
            raw_row[col] = pix;
            col_pos      = col + 1;
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= rows)
                begin
                    row_pos  = 0;
                    draining = 1'b1;
                end
            end
            return 1'b1;
        endfunction

        function void check_output(logic [PIX_W-1:0] px, logic fe);
            filtered_px_t e;
            if (due_q.size() == 0)
            begin
                $error("unexpected transfer: pixel_out %0d frame_end %0b", px, fe);
                errors++;
                return;
            end
            e = due_q.pop_front();
            if (px !== e.pixel)
            begin
                $error("pixel_out: expected %0d, actual %0d", e.pixel, px);
                errors++;
            end
            if (fe !== e.frame_end)
            begin
                $error("frame_end: expected %0b, actual %0b", e.frame_end, fe);
                errors++;
            end
            pixels_checked++;
            if (e.frame_end) frames_checked++;
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  req_type  = REQ_PIXEL;
    logic [PIX_W-1:0]      pixel_in  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  frame_end;

    despeckle_scoreboard sb = new();

    int  scene_level    = 128;
    bit  in_burst       = 1'b0;
    bit  out_burst      = 1'b0;
    int  items_used     = 0;
    int  items_dropped  = 0;
    int  settings_count = 0;
    int  quiet_cycles   = 0;

    conditional_neighbor_despeckle dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly a flat scene with small ripple, plus speckles and full-range values.
    function automatic logic [PIX_W-1:0] draw_pixel();
        int v;
        case ($urandom_range(0, 19))
            0, 1, 2: return PIX_W'($urandom_range(0, 255));
            3:       return 8'h00;
            4:       return 8'hFF;
            default:
            begin
                v = scene_level + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return PIX_W'(v);
            end
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_register(idx, data);
    endtask

    task automatic configure(bit wr_thr, logic [CFG_DATA_W-1:0] thr_data, bit wr_geom,
                             logic [CFG_DATA_W-1:0] rows_data,
                             logic [CFG_DATA_W-1:0] cols_data, bit wr_spare);
        if (wr_thr) write_reg(CFG_THRESHOLD, thr_data);
        if (wr_geom)
        begin
            write_reg(CFG_ROWS, rows_data);
            write_reg(CFG_COLS, cols_data);
        end
        if (wr_spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 2047)));
        if (wr_thr || wr_geom || wr_spare)
        begin
            cfg_valid <= 1'b0;
            settings_count++;
        end
    endtask

    task automatic push_item(logic req, logic [PIX_W-1:0] pix, output bit used);
        int unsigned gap;
        gap = in_burst ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        pixel_in <= pix;
        do @(posedge clk); while (in_ready !== 1'b1);
        used = sb.take_item(req, pix);
        if (used) items_used++;
        else items_dropped++;
    endtask

    // Follow the frame position so most traffic is well-formed frames.
    task automatic run_items(int unsigned n);
        int unsigned done;
        logic        req;
        bit          used;
        done = 0;
        while (done < n)
        begin
            if (sb.draining) req = ($urandom_range(0, 6) == 0) ? REQ_PIXEL : REQ_DRAIN;
            else req = ($urandom_range(0, 12) == 0) ? REQ_DRAIN : REQ_PIXEL;
            push_item(req, draw_pixel(), used);
            if (used) done++;
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.due_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = out_burst ? 0 : $urandom_range(0, 4);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_output(pixel_out, frame_end);
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        logic [PIX_W-1:0]      edge_px [7];
        logic                  edge_req [7];
        logic [PIX_W-1:0]      speckle_img [9];
        logic [PIX_W-1:0]      thr8;
        logic [CFG_DATA_W-1:0] rows_data;
        logic [CFG_DATA_W-1:0] cols_data;
        int unsigned           n;
        bit                    used;
        bit                    first;
        edge_px     = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h33, 8'h5A};
        edge_req    = '{REQ_DRAIN, REQ_PIXEL, REQ_PIXEL, REQ_PIXEL, REQ_PIXEL,
                        REQ_DRAIN, REQ_PIXEL};
        speckle_img = '{8'd10, 8'd10, 8'd10, 8'd10, 8'd200, 8'd10, 8'd10, 8'd10, 8'd10};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Masked threshold of zero, geometry below range clamps to 2x2. Opens with
        // a drain request outside a drain and closes with a pixel inside one.
        configure(1'b1, 11'h700, 1'b1, 11'd1, 11'd0, 1'b0);
        for (int i = 0; i < 7; i++) push_item(edge_req[i], edge_px[i], used);
        in_valid <= 1'b0;
        wait_drained();

        // Isolated bright speckle in a flat 3x3 frame, plus a write to the spare index.
        configure(1'b1, 11'd1, 1'b1, 11'd3, 11'd3, 1'b1);
        for (int i = 0; i < 9; i++) push_item(REQ_PIXEL, speckle_img[i], used);
        for (int i = 0; i < 3; i++) push_item(REQ_DRAIN, draw_pixel(), used);
        in_valid <= 1'b0;
        wait_drained();

        first = 1'b1;
        while ((items_used + items_dropped) < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:       thr8 = 8'd0;
                1:       thr8 = 8'd255;
                default: thr8 = PIX_W'($urandom_range(0, 48));
            endcase
            case ($urandom_range(0, 7))
                0:       cols_data = 11'd2;
                1:       cols_data = 11'd64;
                2:       cols_data = 11'd127;
                3:       cols_data = CFG_DATA_W'($urandom_range(0, 1));
                default: cols_data = CFG_DATA_W'($urandom_range(3, 16));
            endcase
            case ($urandom_range(0, 9))
                0:       rows_data = 11'd2;
                1:       rows_data = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'd2047;
                2:       rows_data = CFG_DATA_W'($urandom_range(0, 1));
                default: rows_data = CFG_DATA_W'($urandom_range(2, 6));
            endcase
            scene_level = $urandom_range(0, 255);
            in_burst    = ($urandom_range(0, 4) == 0);
            out_burst   = ($urandom_range(0, 4) == 0);

            wait_drained();
            configure(first || ($urandom_range(0, 1) != 0),
                      {3'($urandom_range(0, 7)), thr8},
                      first || ($urandom_range(0, 3) != 0), rows_data, cols_data,
                      ($urandom_range(0, 3) == 0));
            first = 1'b0;

            // Cut some phases short so a geometry write lands mid-frame.
            n = (sb.frame_rows() * sb.frame_cols() + sb.frame_cols()) * $urandom_range(1, 2);
            if (n > PHASE_CAP) n = PHASE_CAP;
            if (n > TARGET_ITEMS - items_used - items_dropped)
                n = TARGET_ITEMS - items_used - items_dropped;
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
            run_items(n);
        end

        wait_drained();
        $display("Drove %0d filter items (%0d dropped drain requests) over %0d settings.",
                 items_used, items_dropped, settings_count);
        $display("Checked %0d filtered pixels, %0d of them frame ends.",
                 sb.pixels_checked, sb.frames_checked);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
sv/cnd_pkg.sv
sv/cnd_ram.sv
sv/conditional_neighbor_despeckle.sv
sv/cnd_checker.sv
dv/conditional_neighbor_despeckle_tb.sv
